// ----- hw/rtl/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants for the k-way merge selector.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int MAX_LISTS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_BITS  = 5;
    localparam int LIST_BITS = 4;
    localparam int ELEM_BITS = 32;

    localparam logic [CFG_BITS-1:0] LISTS_RESET = CFG_BITS'(16);

    localparam int IN_FIELD_BITS  = LIST_BITS + ELEM_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ELEM_BITS + LIST_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - OUT_FIELD_BITS;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic [LIST_BITS-1:0]        list_number;
        logic signed [ELEM_BITS-1:0] element_value;
    } kwm_item_t;

    typedef struct packed {
        logic                        valid;
        logic                        merge_done;
        logic [LIST_BITS-1:0]        source_list;
        logic signed [ELEM_BITS-1:0] merged_value;
    } kwm_result_t;

endpackage

// ----- hw/rtl/kwm_min_tree.sv -----
// ----------------------------------------------------------------------------
// kwm_min_tree
// Signed minimum tree over the list heads; equal values resolve to the
// lower list number.
// ----------------------------------------------------------------------------
module kwm_min_tree #(
    parameter int MAX_LISTS  = kwm_pkg::MAX_LISTS_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF,
    parameter int IDX_BITS   = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1
) (
    input  logic [MAX_LISTS-1:0][VALUE_BITS-1:0] values,
    input  logic [MAX_LISTS-1:0]                 candidates,
    output logic signed [VALUE_BITS-1:0]         min_value,
    output logic [IDX_BITS-1:0]                  min_index,
    output logic                                 found
);
    import kwm_pkg::*;

    localparam int LEVELS = $clog2(MAX_LISTS);
    localparam int LEAVES = 1 << LEVELS;
    localparam int NODES  = 2 * LEAVES - 1;

    logic signed [VALUE_BITS-1:0] node_val [NODES];
    logic [IDX_BITS-1:0]          node_idx [NODES];
    logic                         node_vld [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++)
        begin : g_leaf
            if (g < MAX_LISTS)
            begin : g_used
                assign node_val[LEAVES-1+g] = values[g];
                assign node_idx[LEAVES-1+g] = IDX_BITS'(g);
                assign node_vld[LEAVES-1+g] = candidates[g];
            end
            else
            begin : g_pad
                assign node_val[LEAVES-1+g] = '0;
                assign node_idx[LEAVES-1+g] = '0;
                assign node_vld[LEAVES-1+g] = 1'b0;
            end
        end

        for (g = 0; g < LEAVES - 1; g++)
        begin : g_node
            logic take_right;
            assign take_right = node_vld[2*g+2] &&
                                (!node_vld[2*g+1] || (node_val[2*g+2] < node_val[2*g+1]));
            assign node_val[g] = take_right ? node_val[2*g+2] : node_val[2*g+1];
            assign node_idx[g] = take_right ? node_idx[2*g+2] : node_idx[2*g+1];
            assign node_vld[g] = node_vld[2*g+1] || node_vld[2*g+2];
        end
    endgenerate

    assign min_value = node_val[0];
    assign min_index = node_idx[0];
    assign found     = node_vld[0];

endmodule

// ----- hw/rtl/kwm_slots.sv -----
// ----------------------------------------------------------------------------
// kwm_slots
// Head registers with full and finished flags, slot update, readiness check
// and selection of the next merged result.
// ----------------------------------------------------------------------------
module kwm_slots #(
    parameter int MAX_LISTS  = kwm_pkg::MAX_LISTS_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  kwm_pkg::kwm_item_t             item,
    input  logic [kwm_pkg::CFG_BITS-1:0]   lists_in_use,
    output kwm_pkg::kwm_result_t           result
);
    import kwm_pkg::*;

    localparam int IDX_BITS = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;

    logic [MAX_LISTS-1:0][VALUE_BITS-1:0] head_reg;
    logic [MAX_LISTS-1:0]                 full_reg;
    logic [MAX_LISTS-1:0]                 full_next;
    logic [MAX_LISTS-1:0]                 fin_reg;
    logic [MAX_LISTS-1:0]                 fin_next;

    logic [CFG_BITS-1:0]                  lists_eff;
    logic [MAX_LISTS-1:0]                 act_mask;
    logic [MAX_LISTS-1:0]                 wr;
    logic [MAX_LISTS-1:0]                 eff_full;
    logic [MAX_LISTS-1:0]                 eff_fin;
    logic [MAX_LISTS-1:0][VALUE_BITS-1:0] eff_head;
    logic [MAX_LISTS-1:0]                 cand;
    logic [MAX_LISTS-1:0]                 pop;
    logic signed [VALUE_BITS-1:0]         new_value;
    logic signed [VALUE_BITS-1:0]         best_val;
    logic [IDX_BITS-1:0]                  best_idx;
    logic                                 have;
    logic                                 all_done;
    logic                                 all_ready;
    logic                                 emit_value;

    assign lists_eff = (lists_in_use == '0) ? CFG_BITS'(1) : lists_in_use;
    assign new_value = VALUE_BITS'(item.element_value);

    always_comb
    begin
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            act_mask[i] = 32'(i) < 32'(lists_eff);
            wr[i]       = go && act_mask[i] && (32'(item.list_number) == 32'(i)) &&
                          !full_reg[i] && !fin_reg[i];
            eff_full[i] = full_reg[i] || (wr[i] && (item.kind == KIND_ELEMENT));
            eff_fin[i]  = fin_reg[i] || (wr[i] && (item.kind == KIND_END));
            eff_head[i] = (wr[i] && (item.kind == KIND_ELEMENT)) ? new_value : head_reg[i];
        end
    end

    assign all_done  = &(eff_fin | ~act_mask);
    assign all_ready = &(eff_full | eff_fin | ~act_mask);
    assign cand      = eff_full & act_mask;

    kwm_min_tree #(
        .MAX_LISTS  (MAX_LISTS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_BITS   (IDX_BITS)
    ) u_min_tree (
        .values     (eff_head),
        .candidates (cand),
        .min_value  (best_val),
        .min_index  (best_idx),
        .found      (have)
    );

    assign emit_value = go && !all_done && all_ready && have;

    always_comb
    begin
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            pop[i] = emit_value && (best_idx == IDX_BITS'(i));
        end
        if (go && all_done)
        begin
            full_next = '0;
            fin_next  = '0;
        end
        else
        begin
            full_next = eff_full & ~pop;
            fin_next  = eff_fin;
        end
    end

    always_comb
    begin
        result.valid        = (go && all_done) || emit_value;
        result.merge_done   = all_done;
        result.source_list  = all_done ? '0 : LIST_BITS'(best_idx);
        result.merged_value = all_done ? '0 : ELEM_BITS'(best_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
            fin_reg  <= '0;
        end
        else
        begin
            full_reg <= full_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            if (wr[i] && (item.kind == KIND_ELEMENT))
            begin
                head_reg[i] <= new_value;
            end
        end
    end

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && all_done |=> (full_reg == '0) && (fin_reg == '0))
        else $error("Done marker did not clear the slot flags.");

    a_pop_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit_value |=> !full_reg[$past(best_idx)])
        else $error("Selected slot is still full after its value went out.");

    a_pop_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pop))
        else $error("More than one slot released in one cycle.");

    a_pop_from_full: assert property (@(posedge clk) disable iff (!rst_n)
        emit_value |-> eff_full[best_idx] && act_mask[best_idx])
        else $error("Selected slot holds no active head.");

endmodule

// ----- hw/rtl/k_way_merge_selector_unit.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_selector_unit
// Merges up to MAX_LISTS ascending streams into one ascending stream.
//
//   Channel   Direction  Transfer contents
//   s_axis    in         tuser: kind; tdata: list_number, element_value
//   m_axis    out        tuser: merge_done; tdata: merged_value, source_list
//   cfg       in         lists_in_use, written when cfg_we is high
//
// One input transfer is taken per cycle while the output is not stalled. A
// transfer is registered, then resolved against the head slots and the
// minimum tree, and any result it yields is registered in the output register.
// The result register and the input register keep both sides moving; a
// stalled output holds the input register. Reset clears all flags and sets
// lists_in_use to 16.
// ----------------------------------------------------------------------------
module k_way_merge_selector_unit #(
    parameter int MAX_LISTS  = kwm_pkg::MAX_LISTS_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [kwm_pkg::CFG_BITS-1:0]         cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: list_number[3:0], element_value[35:4], zero pad.
    input  logic [kwm_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,
    // Fields from bit 0: kind.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: merged_value[31:0], source_list[35:32], zero pad.
    output logic [kwm_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,
    // Fields from bit 0: merge_done.
    output logic                                 m_axis_tuser
);
    import kwm_pkg::*;

    logic [CFG_BITS-1:0] lists_reg;
    logic                in_valid_reg;
    kwm_item_t           item_reg;
    kwm_item_t           item_next;
    logic                out_valid_reg;
    kwm_result_t         out_reg;
    kwm_result_t         result;
    logic                go;

    assign item_next.kind          = s_axis_tuser;
    assign item_next.list_number   = s_axis_tdata[LIST_BITS-1:0];
    assign item_next.element_value = s_axis_tdata[LIST_BITS+ELEM_BITS-1:LIST_BITS];

    assign go            = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || go;

    kwm_slots #(
        .MAX_LISTS  (MAX_LISTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_slots (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .item         (item_reg),
        .lists_in_use (lists_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_reg     <= LISTS_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lists_reg <= cfg_wdata;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (go)
            begin
                out_valid_reg <= result.valid;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= item_next;
        end
        if (go && result.valid)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_reg.source_list, out_reg.merged_value};
    assign m_axis_tuser  = out_reg.merge_done;

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !go)
        else $error("Item resolved while the result register was blocked.");

    a_go_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> s_axis_tready)
        else $error("Input register not freed by a resolved item.");

    a_done_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.merge_done |-> m_axis_tdata == '0)
        else $error("Done marker carries a value.");

endmodule
